[hw/rtl/vmpw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpw_pkg
// Shared constants, types and the erf lookup table of the voxel margin
// point weight core.
// ----------------------------------------------------------------------------
package vmpw_pkg;

    // erf table geometry: entries cover z in [0, ERF_Z_MAX]
    localparam int ERF_TABLE_ENTRIES = 256;
    localparam int ERF_Z_MAX         = 6;

    // voxel size register
    localparam int          VS_W        = 24;
    localparam logic [23:0] VOXEL_RESET = 24'd32768;

    // pipeline depths of the iterative units
    localparam int DIV_STEPS  = 32;   // remainder, one dividend bit per stage
    localparam int SQRT_STEPS = 24;   // square root, one root bit per stage
    localparam int QUO_STEPS  = 19;   // quotient z16, one bit per stage

    // lookup widths
    localparam int TI_W  = $clog2(ERF_TABLE_ENTRIES + 1);
    localparam int XW    = QUO_STEPS + $clog2(ERF_TABLE_ENTRIES);
    localparam int POS_W = 16 + $clog2(ERF_TABLE_ENTRIES);
    localparam logic [QUO_STEPS-1:0] Z16_MAX = QUO_STEPS'(ERF_Z_MAX * 65536);
    localparam logic [31:0] ZM_RECIP = 32'(64'h1_0000_0000 / ERF_Z_MAX);
    localparam logic [TI_W-1:0] LAST_IDX = TI_W'(ERF_TABLE_ENTRIES - 1);

    // mid queue
    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = 2;

    // item handed from front to back
    typedef struct packed {
        logic        pv;
        logic [24:0] m2;
        logic [31:0] vsel;
    } t_mid;

    // remainder pipeline stage
    typedef struct packed {
        logic             pv;
        logic [2:0]       neg;
        logic [2:0][31:0] dvd;
        logic [2:0][23:0] rem;
        logic [2:0][31:0] vr;
    } t_rdiv;

    // offset magnitude stage
    typedef struct packed {
        logic             pv;
        logic [2:0][24:0] mag;
        logic [2:0][31:0] vr;
    } t_fmag;

    // square root stage
    typedef struct packed {
        logic        pv;
        logic [24:0] m2;
        logic [47:0] rad;
        logic [26:0] rem;
        logic [23:0] root;
    } t_sqst;

    // quotient stage
    typedef struct packed {
        logic                 pv;
        logic                 ovf;
        logic [23:0]          den;
        logic [23:0]          rem;
        logic [QUO_STEPS-1:0] q;
    } t_qst;

    // result transaction
    typedef struct packed {
        logic [15:0] weight;
        logic        wvalid;
    } t_res;

    typedef logic [15:0] t_erf_tab [0:ERF_TABLE_ENTRIES];

    // unsigned 64-bit quotient by shift and subtract, for table building only
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q40 product of two Q40 values
    function automatic logic [63:0] mul_q40(logic [63:0] a, logic [63:0] b);
        logic [63:0] p1;
        logic [63:0] p2;
        p1 = a * (b >> 20);
        p2 = a * (b & 64'hF_FFFF);
        return (p1 >> 20) + (p2 >> 40);
    endfunction

    // exp(-f) in Q40, f in Q16 within [0, 1]
    function automatic logic [63:0] exp_neg_frac(logic [63:0] f16);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        pos  = 64'd1 << 40;
        neg  = 64'd0;
        term = 64'd1 << 40;
        for (int n = 1; n <= 40; n++) begin
            term = udiv64((term * f16) >> 16, 64'(n));
            if ((n & 1) == 1) neg = neg + term;
            else              pos = pos + term;
        end
        return pos - neg;
    endfunction

    // exp(-y) in Q40, y in Q16
    function automatic logic [63:0] exp_neg_q16(logic [63:0] y16);
        logic [63:0] whole;
        logic [63:0] r;
        logic [63:0] e1;
        whole = y16 >> 16;
        r     = exp_neg_frac(y16 & 64'hFFFF);
        e1    = exp_neg_frac(64'd65536);
        for (int i = 0; i < 64; i++) begin
            if (64'(i) < whole) r = mul_q40(r, e1);
        end
        return r;
    endfunction

    // one table entry: erf(x / sqrt 2) as a 16-bit fraction
    function automatic logic [15:0] erf_entry(int k);
        logic [63:0] nn;
        logic [63:0] xq;
        logic [63:0] x2q;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        nn   = 64'(ERF_TABLE_ENTRIES);
        xq   = udiv64(64'(k) * 64'(ERF_Z_MAX) * 64'd65536, nn);
        x2q  = udiv64(64'(k) * 64'(k) * 64'(ERF_Z_MAX) * 64'(ERF_Z_MAX) * 64'd65536,
                      nn * nn);
        term = (exp_neg_q16(x2q >> 1) * xq) >> 16;
        sum  = 64'd0;
        for (int j = 0; j < 400; j++) begin
            if (term != 64'd0) begin
                sum  = sum + term;
                term = udiv64((term * x2q) >> 16, 64'(2 * j + 3));
            end
        end
        v = (sum * 64'd836643 + (64'd1 << 43)) >> 44;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_erf_tab erf_build();
        t_erf_tab t;
        for (int k = 0; k <= ERF_TABLE_ENTRIES; k++) t[k] = erf_entry(k);
        return t;
    endfunction

    localparam t_erf_tab ERF_TAB = erf_build();

endpackage

[hw/rtl/vmpw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpw_front
// Accepts points, reduces each coordinate modulo the voxel size and picks
// the axis with the smallest margin to the cell wall.
// ----------------------------------------------------------------------------
module vmpw_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [23:0]           i_s,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [31:0]           i_pos_x,
    input  logic [31:0]           i_pos_y,
    input  logic [31:0]           i_pos_z,
    input  logic [31:0]           i_var_x,
    input  logic [31:0]           i_var_y,
    input  logic [31:0]           i_var_z,
    input  logic                  i_point_valid,
    output logic                  o_q_push,
    input  logic                  i_q_full,
    output vmpw_pkg::t_mid        o_q_din
);
    import vmpw_pkg::*;

    t_rdiv r_st [0:DIV_STEPS];
    logic  r_occ_st [0:DIV_STEPS];
    t_fmag r_f1;
    logic  r_occ_f1;
    t_mid  r_f2;
    logic  r_occ_f2;

    logic  en;
    t_rdiv n_st0;
    t_fmag n_f1;
    t_mid  n_f2;

    // one restoring remainder step on all three axes
    function automatic t_rdiv rem_step(t_rdiv a, logic [23:0] s);
        t_rdiv       o;
        logic [24:0] r2;
        o = a;
        for (int k = 0; k < 3; k++) begin
            r2 = {a.rem[k], a.dvd[k][31]};
            if (r2 >= {1'b0, s}) r2 = r2 - {1'b0, s};
            o.rem[k] = r2[23:0];
            o.dvd[k] = {a.dvd[k][30:0], 1'b0};
        end
        return o;
    endfunction

    // whole pipe moves unless the last stage is blocked
    assign en       = !(r_occ_f2 && i_q_full);
    assign o_full   = !en;
    assign o_q_push = r_occ_f2 && !i_q_full;
    assign o_q_din  = r_f2;

    // entry: magnitudes and signs
    always_comb begin
        logic [2:0][31:0] p;
        p = {i_pos_z, i_pos_y, i_pos_x};
        n_st0.pv = i_point_valid;
        n_st0.vr = {i_var_z, i_var_y, i_var_x};
        for (int k = 0; k < 3; k++) begin
            n_st0.neg[k] = p[k][31];
            n_st0.dvd[k] = p[k][31] ? 32'(-p[k]) : p[k];
            n_st0.rem[k] = '0;
        end
    end

    // floor remainder and offset magnitude
    always_comb begin
        logic [23:0] r;
        logic [25:0] d;
        n_f1.pv = r_st[DIV_STEPS].pv;
        n_f1.vr = r_st[DIV_STEPS].vr;
        for (int k = 0; k < 3; k++) begin
            r = r_st[DIV_STEPS].rem[k];
            if (r_st[DIV_STEPS].neg[k] && r != 24'd0) r = i_s - r;
            d = {1'b0, r, 1'b0} - {2'b00, i_s};
            n_f1.mag[k] = d[25] ? 25'(-d) : d[24:0];
        end
    end

    // axis pick, margin and variance floor
    always_comb begin
        logic [1:0] ax;
        if (r_f1.mag[1] >= r_f1.mag[0] && r_f1.mag[1] >= r_f1.mag[2]) ax = 2'd1;
        else if (r_f1.mag[2] >= r_f1.mag[0] && r_f1.mag[2] >= r_f1.mag[1]) ax = 2'd2;
        else ax = 2'd0;
        n_f2.pv   = r_f1.pv;
        n_f2.m2   = {1'b0, i_s} - r_f1.mag[ax];
        n_f2.vsel = (r_f1.vr[ax] == 32'd0) ? 32'd1 : r_f1.vr[ax];
    end

    // stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_occ_st[k] <= 1'b0;
            r_occ_f1 <= 1'b0;
            r_occ_f2 <= 1'b0;
        end else if (en) begin
            r_occ_st[0] <= i_push;
            for (int k = 1; k <= DIV_STEPS; k++) r_occ_st[k] <= r_occ_st[k-1];
            r_occ_f1 <= r_occ_st[DIV_STEPS];
            r_occ_f2 <= r_occ_f1;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= n_st0;
            for (int k = 1; k <= DIV_STEPS; k++) r_st[k] <= rem_step(r_st[k-1], i_s);
            r_f1 <= n_f1;
            r_f2 <= n_f2;
        end
    end

endmodule

[hw/rtl/vmpw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpw_queue
// Short queue between the front and the back, so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module vmpw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vmpw_pkg::t_mid i_din,
    output logic           o_full,
    input  logic           i_pop,
    output vmpw_pkg::t_mid o_dout,
    output logic           o_empty
);
    import vmpw_pkg::*;

    t_mid             r_mem [0:MQ_DEPTH-1];
    logic [MQ_AW-1:0] r_wp;
    logic [MQ_AW-1:0] r_rp;
    logic [MQ_AW:0]   r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == (MQ_AW+1)'(MQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_dout  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            if (wr && !rd)      r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_din;
    end

endmodule

[hw/rtl/vmpw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpw_back
// Takes margin and variance, forms sigma and z = margin / sigma, and reads
// the interpolated erf weight into a two-entry result queue.
// ----------------------------------------------------------------------------
module vmpw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  vmpw_pkg::t_mid i_q_dout,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [15:0]    o_weight,
    output logic           o_weight_valid
);
    import vmpw_pkg::*;

    t_sqst r_sq [0:SQRT_STEPS];
    logic  r_occ_sq [0:SQRT_STEPS];
    t_qst  r_dv [0:QUO_STEPS];
    logic  r_occ_dv [0:QUO_STEPS];

    // lookup stages
    logic            r_occ_lx, r_occ_lp, r_occ_lq, r_occ_lt, r_occ_w;
    logic            r_lx_pv, r_lp_pv, r_lq_pv, r_lt_pv;
    logic            r_lx_big, r_lp_big, r_lq_big, r_lt_big;
    logic [XW-1:0]   r_lx_x, r_lp_x;
    logic [XW+31:0]  r_lp_prod;
    logic [POS_W-1:0] r_lq_pos;
    logic [15:0]     r_lt_t0;
    logic [31:0]     r_lt_prod;
    logic            r_lt_up;
    t_res            r_w;

    // result queue
    t_res        r_oq [0:1];
    logic        r_oq_wp;
    logic        r_oq_rp;
    logic [1:0]  r_oq_cnt;
    logic        oq_full;
    logic        oq_wr;
    logic        oq_rd;

    logic        en;
    t_sqst       n_sq0;
    t_qst        n_dv0;
    logic [POS_W-1:0] n_pos;
    logic [15:0] n_t0;
    logic [31:0] n_tprod;
    logic        n_up;
    t_res        n_w;

    // one square root step: two radicand bits in, one root bit out
    function automatic t_sqst sqrt_step(t_sqst a);
        t_sqst       o;
        logic [26:0] r;
        logic [26:0] t;
        o = a;
        r = {a.rem[24:0], a.rad[47:46]};
        t = {1'b0, a.root, 2'b01};
        if (r >= t) begin
            o.rem  = r - t;
            o.root = {a.root[22:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {a.root[22:0], 1'b0};
        end
        o.rad = {a.rad[45:0], 2'b00};
        return o;
    endfunction

    // one restoring quotient step
    function automatic t_qst quo_step(t_qst a);
        t_qst        o;
        logic [24:0] r;
        o = a;
        r = {a.rem, 1'b0};
        if (r >= {1'b0, a.den}) begin
            r   = r - {1'b0, a.den};
            o.q = {a.q[QUO_STEPS-2:0], 1'b1};
        end else begin
            o.q = {a.q[QUO_STEPS-2:0], 1'b0};
        end
        o.rem = r[23:0];
        return o;
    endfunction

    assign oq_full = (r_oq_cnt == 2'd2);
    assign en      = !(r_occ_w && oq_full);
    assign o_q_pop = en && !i_q_empty;
    assign oq_wr   = r_occ_w && !oq_full;
    assign oq_rd   = i_pop && !o_empty;
    assign o_empty = (r_oq_cnt == 2'd0);
    assign o_weight       = r_oq[r_oq_rp].weight;
    assign o_weight_valid = r_oq[r_oq_rp].wvalid;

    // root entry: variance in 2^-32 m^2 scaled to 2^-48 m^2
    always_comb begin
        n_sq0.pv   = i_q_dout.pv;
        n_sq0.m2   = i_q_dout.m2;
        n_sq0.rad  = {i_q_dout.vsel, 16'h0000};
        n_sq0.rem  = '0;
        n_sq0.root = '0;
    end

    // quotient entry: saturate when z16 needs more than the kept bits
    always_comb begin
        logic [28:0] top;
        top       = {r_sq[SQRT_STEPS].m2, 4'b0000};
        n_dv0.pv  = r_sq[SQRT_STEPS].pv;
        n_dv0.den = r_sq[SQRT_STEPS].root;
        n_dv0.ovf = (top >= {5'b00000, r_sq[SQRT_STEPS].root});
        n_dv0.rem = n_dv0.ovf ? 24'd0 : top[23:0];
        n_dv0.q   = '0;
    end

    // exact divide by the z range: reciprocal estimate, one correction
    always_comb begin
        logic [XW-1:0]   q0;
        logic [XW+2:0]   q6;
        logic [XW-1:0]   rm;
        q0 = r_lp_prod[XW+31:32];
        q6 = (XW+3)'(q0) * (XW+3)'(ERF_Z_MAX);
        rm = r_lp_x - q6[XW-1:0];
        if (rm >= XW'(ERF_Z_MAX)) q0 = q0 + 1'b1;
        n_pos = q0[POS_W-1:0];
    end

    // table read and interpolation product
    always_comb begin
        logic [TI_W-1:0] idx;
        logic [15:0]     t1;
        logic [15:0]     df;
        idx = TI_W'(r_lq_pos >> 16);
        if (idx > LAST_IDX) idx = LAST_IDX;
        n_t0 = ERF_TAB[idx];
        t1   = ERF_TAB[idx + 1'b1];
        n_up = (t1 >= n_t0);
        df   = n_up ? t1 - n_t0 : n_t0 - t1;
        n_tprod = df * r_lq_pos[15:0];
    end

    // final weight
    always_comb begin
        logic [15:0] dn;
        logic [16:0] sum;
        dn  = r_lt_prod[31:16];
        sum = {1'b0, r_lt_t0} + {1'b0, dn};
        priority if (!r_lt_pv) n_w.weight = 16'd0;
        else if (r_lt_big)     n_w.weight = ERF_TAB[ERF_TABLE_ENTRIES];
        else if (r_lt_up)      n_w.weight = sum[16] ? 16'hFFFF : sum[15:0];
        else if (dn > r_lt_t0) n_w.weight = 16'd0;
        else                   n_w.weight = r_lt_t0 - dn;
        n_w.wvalid = r_lt_pv;
    end

    // stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQRT_STEPS; k++) r_occ_sq[k] <= 1'b0;
            for (int k = 0; k <= QUO_STEPS; k++)  r_occ_dv[k] <= 1'b0;
            r_occ_lx <= 1'b0;
            r_occ_lp <= 1'b0;
            r_occ_lq <= 1'b0;
            r_occ_lt <= 1'b0;
            r_occ_w  <= 1'b0;
        end else if (en) begin
            r_occ_sq[0] <= !i_q_empty;
            for (int k = 1; k <= SQRT_STEPS; k++) r_occ_sq[k] <= r_occ_sq[k-1];
            r_occ_dv[0] <= r_occ_sq[SQRT_STEPS];
            for (int k = 1; k <= QUO_STEPS; k++) r_occ_dv[k] <= r_occ_dv[k-1];
            r_occ_lx <= r_occ_dv[QUO_STEPS];
            r_occ_lp <= r_occ_lx;
            r_occ_lq <= r_occ_lp;
            r_occ_lt <= r_occ_lq;
            r_occ_w  <= r_occ_lt;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0] <= n_sq0;
            for (int k = 1; k <= SQRT_STEPS; k++) r_sq[k] <= sqrt_step(r_sq[k-1]);
            r_dv[0] <= n_dv0;
            for (int k = 1; k <= QUO_STEPS; k++) r_dv[k] <= quo_step(r_dv[k-1]);
            // table position numerator
            r_lx_pv  <= r_dv[QUO_STEPS].pv;
            r_lx_big <= r_dv[QUO_STEPS].ovf || (r_dv[QUO_STEPS].q >= Z16_MAX);
            r_lx_x   <= XW'(r_dv[QUO_STEPS].q) * XW'(ERF_TABLE_ENTRIES);
            // reciprocal product
            r_lp_pv   <= r_lx_pv;
            r_lp_big  <= r_lx_big;
            r_lp_x    <= r_lx_x;
            r_lp_prod <= (XW+32)'(r_lx_x) * (XW+32)'(ZM_RECIP);
            // table position
            r_lq_pv  <= r_lp_pv;
            r_lq_big <= r_lp_big;
            r_lq_pos <= n_pos;
            // table read
            r_lt_pv   <= r_lq_pv;
            r_lt_big  <= r_lq_big;
            r_lt_t0   <= n_t0;
            r_lt_prod <= n_tprod;
            r_lt_up   <= n_up;
            r_w       <= n_w;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (oq_wr) r_oq_wp <= !r_oq_wp;
            if (oq_rd) r_oq_rp <= !r_oq_rp;
            if (oq_wr && !oq_rd)      r_oq_cnt <= r_oq_cnt + 2'd1;
            else if (oq_rd && !oq_wr) r_oq_cnt <= r_oq_cnt - 2'd1;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (oq_wr) r_oq[r_oq_wp] <= r_w;
    end

endmodule

[hw/rtl/voxel_margin_point_weight_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_margin_point_weight_core
// Weights one lidar point per cycle, while full is low, by the erf of its voxel-wall margin.
// ----------------------------------------------------------------------------
// Accepts one point every clock cycle while full is low and returns one
// weight per point, in order. A point passes 35 front stages (a 32-step
// remainder by the voxel size, then axis pick), the mid queue, 25 square
// root stages, 20 quotient stages, 5 lookup stages and the result queue.
// The remainder, root and quotient units each resolve one bit per stage.
// Write the voxel edge only while no point is in flight; a size of zero
// acts as one.
// ----------------------------------------------------------------------------
module voxel_margin_point_weight_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_var_x,
    input  logic [31:0] i_var_y,
    input  logic [31:0] i_var_z,
    input  logic        i_point_valid,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] o_weight,
    output logic        o_weight_valid
);
    import vmpw_pkg::*;

    logic [23:0] r_vox_edge;
    logic [23:0] s_eff;
    logic        mq_push;
    logic        mq_full;
    logic        mq_pop;
    logic        mq_empty;
    t_mid        mq_din;
    t_mid        mq_dout;

    // voxel size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vox_edge <= VOXEL_RESET;
        end else if (i_cfg_we) begin
            r_vox_edge <= i_cfg_wdata;
        end
    end

    assign s_eff = (r_vox_edge == 24'd0) ? 24'd1 : r_vox_edge;

    // front: cell offset and axis pick
    vmpw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s           (s_eff),
        .i_push        (push),
        .o_full        (full),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_var_x       (i_var_x),
        .i_var_y       (i_var_y),
        .i_var_z       (i_var_z),
        .i_point_valid (i_point_valid),
        .o_q_push      (mq_push),
        .i_q_full      (mq_full),
        .o_q_din       (mq_din)
    );

    // decoupling queue
    vmpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .i_din   (mq_din),
        .o_full  (mq_full),
        .i_pop   (mq_pop),
        .o_dout  (mq_dout),
        .o_empty (mq_empty)
    );

    // back: sigma, z and erf lookup
    vmpw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (mq_empty),
        .i_q_dout       (mq_dout),
        .o_q_pop        (mq_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_weight       (o_weight),
        .o_weight_valid (o_weight_valid)
    );

endmodule
